// ----- hdl/msd_pkg.sv -----
package msd_pkg;

  // Register indexes (byte address / 4).
  localparam logic [2:0] REG_SPEED_THR = 3'd0;
  localparam logic [2:0] REG_DEV_FRAC  = 3'd1;
  localparam logic [2:0] REG_SCALE     = 3'd2;
  localparam logic [2:0] REG_MAX_GAP   = 3'd3;
  localparam logic [2:0] REG_MIN_POS   = 3'd4;

  localparam logic [23:0] RST_SPEED_THR = 24'd0;
  localparam logic [15:0] RST_DEV_FRAC  = 16'd13107;
  localparam logic [23:0] RST_SCALE     = 24'd65536;
  localparam logic [15:0] RST_MAX_GAP   = 16'd100;
  localparam logic [31:0] RST_MIN_POS   = 32'd0;

  localparam logic [9:0] MS_PER_S = 10'd1000;

  // Dividend width: a 33 bit delta times 1000.
  localparam int DIV_W = 43;
  localparam int CNT_W = $clog2(DIV_W);
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 24;
  localparam int PROD_W = MUL_A_W + MUL_B_W;

  typedef struct packed {
    logic [23:0] speed_threshold;
    logic [15:0] deviation_fraction;
    logic [23:0] speed_scale;
    logic [15:0] max_gap_ms;
    logic [31:0] min_position;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic mul_d;
    logic div_step;
    logic mul_s;
    logic mul_u;
    logic mul_l;
    logic cmp;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic checked;
    logic div_last;
  } dp_sts_t;

  typedef struct packed {
    logic [31:0] measured_speed;
    logic        checked;
    logic        stalled;
  } result_t;

endpackage

// ----- hdl/msd_ctrl.sv -----
module msd_ctrl
  import msd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    out_free,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_EVAL  = 9'b000000010,
    ST_MUL_D = 9'b000000100,
    ST_DIV   = 9'b000001000,
    ST_MUL_S = 9'b000010000,
    ST_MUL_U = 9'b000100000,
    ST_MUL_L = 9'b001000000,
    ST_CMP   = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.checked ? ST_MUL_D : ST_DONE;
      end
      ST_MUL_D: begin
        cmd.mul_d = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_MUL_S;
      end
      ST_MUL_S: begin
        cmd.mul_s = 1'b1;
        state_nxt = ST_MUL_U;
      end
      ST_MUL_U: begin
        cmd.mul_u = 1'b1;
        state_nxt = ST_MUL_L;
      end
      ST_MUL_L: begin
        cmd.mul_l = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        cmd.commit = out_free;
        if (out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

endmodule

// ----- hdl/msd_dp.sv -----
module msd_dp
  import msd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic [31:0] in_position,
  input  logic [31:0] in_time_ms,
  input  logic [23:0] in_motor_speed,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  output result_t     res
);

  logic [31:0]        pos_r;
  logic [31:0]        now_r;
  logic [23:0]        motor_r;
  logic [31:0]        last_pos_r;
  logic [31:0]        last_time_r;
  logic [15:0]        gap_r;
  logic [32:0]        delta_r;
  logic               checked_r;
  logic [31:0]        speed_r;
  logic               stalled_r;
  logic [DIV_W-1:0]   quo_r;
  logic [15:0]        rem_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [PROD_W-1:0]  prod_r;
  logic [33:0]        scaled_r;
  logic [33:0]        upper_r;

  logic [31:0]        gap_w;
  logic               checked_w;
  logic [32:0]        diff_w;
  logic [32:0]        delta_w;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod_w;
  logic [16:0]        rem_sh_w;
  logic               q_bit;
  logic [15:0]        rem_w;
  logic [31:0]        sat_w;
  logic [49:0]        rnd_w;
  logic [33:0]        round_w;
  logic               above_thr;

  assign gap_w     = now_r - last_time_r;
  assign checked_w = (gap_w != 32'd0) && (gap_w < {16'd0, cfg.max_gap_ms}) &&
                     ($signed(pos_r) > $signed(cfg.min_position));
  assign diff_w    = {pos_r[31], pos_r} - {last_pos_r[31], last_pos_r};
  assign delta_w   = diff_w[32] ? (33'd0 - diff_w) : diff_w;

  // One shared multiplier serves the rate product, the scaled motor speed and the two bound products.
  always_comb begin
    if (cmd.mul_d) begin
      mul_a = delta_r;
      mul_b = {14'd0, MS_PER_S};
    end else if (cmd.mul_s) begin
      mul_a = {9'd0, motor_r};
      mul_b = cfg.speed_scale;
    end else if (cmd.mul_u) begin
      mul_a = {1'b0, speed_r};
      mul_b = {7'd0, 17'h10000 + {1'b0, cfg.deviation_fraction}};
    end else begin
      mul_a = {1'b0, speed_r};
      mul_b = {7'd0, 17'h10000 - {1'b0, cfg.deviation_fraction}};
    end
  end

  assign prod_w = {24'd0, mul_a} * {33'd0, mul_b};

  // Restoring division, one quotient bit per step.
  assign rem_sh_w = {rem_r, quo_r[DIV_W-1]};
  assign q_bit    = (rem_sh_w >= {1'b0, gap_r});
  assign rem_w    = q_bit ? 16'(rem_sh_w - {1'b0, gap_r}) : rem_sh_w[15:0];

  assign sat_w = (quo_r[DIV_W-1:32] != '0) ? 32'hFFFF_FFFF : quo_r[31:0];

  // Round half up and drop the 16 fraction bits.
  assign rnd_w   = prod_r[49:0] + 50'd32768;
  assign round_w = rnd_w[49:16];

  assign above_thr = (speed_r > {8'd0, cfg.speed_threshold}) &&
                     (motor_r > cfg.speed_threshold);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pos_r   <= in_position;
      now_r   <= in_time_ms;
      motor_r <= in_motor_speed;
    end
    if (cmd.eval) begin
      gap_r     <= gap_w[15:0];
      delta_r   <= delta_w;
      checked_r <= checked_w;
      speed_r   <= 32'd0;
      stalled_r <= 1'b0;
    end
    if (cmd.mul_d) begin
      quo_r <= prod_w[DIV_W-1:0];
      rem_r <= 16'd0;
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      quo_r <= {quo_r[DIV_W-2:0], q_bit};
      rem_r <= rem_w;
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.mul_s || cmd.mul_u || cmd.mul_l) begin
      prod_r <= prod_w;
    end
    if (cmd.mul_s) begin
      speed_r <= sat_w;
    end
    if (cmd.mul_u) begin
      scaled_r <= round_w;
    end
    if (cmd.mul_l) begin
      upper_r <= round_w;
    end
    if (cmd.cmp) begin
      stalled_r <= above_thr && ((scaled_r > upper_r) || (scaled_r < round_w));
    end
  end

  // A stalled sample leaves the stored reference untouched.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pos_r  <= 32'd0;
      last_time_r <= 32'd0;
    end else if (cmd.commit && !stalled_r) begin
      last_pos_r  <= pos_r;
      last_time_r <= now_r;
    end
  end

  assign sts.checked  = checked_w;
  assign sts.div_last = (cnt_r == CNT_W'(DIV_W - 1));

  assign res.measured_speed = speed_r;
  assign res.checked        = checked_r;
  assign res.stalled        = stalled_r;

endmodule

// ----- hdl/motor_stall_detector.sv -----
// A sample that fails the gap or position check gives its result word after
// evaluation; a checked sample first passes the delta product, the 43-step
// bit-serial divider, the scale and bound products and a compare, one shared
// multiplier being used four times. Each sample is committed before the next is
// taken; a finished word may wait in the output register while the next is accepted.
// Reset (rst_n, synchronous): registers to defaults, stored sample to zero.
module motor_stall_detector
  import msd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,    // position[31:0], time_ms[63:32], motor_speed[87:64]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // stalled[0], checked[1], measured_speed[33:2], zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t        cfg_r;
  logic        out_valid_r;
  logic [33:0] out_data_r;
  logic        wr_en;
  logic [2:0]  reg_idx;
  logic        out_free;
  dp_cmd_t     cmd;
  dp_sts_t     sts;
  result_t     res;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_threshold    <= RST_SPEED_THR;
      cfg_r.deviation_fraction <= RST_DEV_FRAC;
      cfg_r.speed_scale        <= RST_SCALE;
      cfg_r.max_gap_ms         <= RST_MAX_GAP;
      cfg_r.min_position       <= RST_MIN_POS;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SPEED_THR: cfg_r.speed_threshold    <= cfg_pwdata[23:0];
        REG_DEV_FRAC:  cfg_r.deviation_fraction <= cfg_pwdata[15:0];
        REG_SCALE:     cfg_r.speed_scale        <= cfg_pwdata[23:0];
        REG_MAX_GAP:   cfg_r.max_gap_ms         <= cfg_pwdata[15:0];
        REG_MIN_POS:   cfg_r.min_position       <= cfg_pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SPEED_THR: cfg_prdata = {8'd0, cfg_r.speed_threshold};
      REG_DEV_FRAC:  cfg_prdata = {16'd0, cfg_r.deviation_fraction};
      REG_SCALE:     cfg_prdata = {8'd0, cfg_r.speed_scale};
      REG_MAX_GAP:   cfg_prdata = {16'd0, cfg_r.max_gap_ms};
      REG_MIN_POS:   cfg_prdata = cfg_r.min_position;
      default:       cfg_prdata = 32'd0;
    endcase
  end

  assign out_free = !out_valid_r || out_tready;

  msd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd)
  );

  msd_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_position    (in_tdata[31:0]),
    .in_time_ms     (in_tdata[63:32]),
    .in_motor_speed (in_tdata[87:64]),
    .cmd            (cmd),
    .sts            (sts),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= {res.measured_speed, res.checked, res.stalled};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_data_r};

`ifndef NO_ASSERTIONS
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_tready))
    else $error("result committed over an untaken word");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input ready again right after acceptance");

  a_unchecked_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[1]) |-> (out_tdata[33:2] == 32'd0 && !out_tdata[0]))
    else $error("unchecked word carries speed or stall");
`endif

endmodule

// ----- sim/motor_stall_detector_tb.sv -----
`timescale 1ns / 100ps

module motor_stall_detector_tb;
  import msd_pkg::*;

  localparam logic [2:0] REG_UNUSED  = 3'd7;
  localparam longint     POS_MAX     = 64'sd2147483647;
  localparam int         STALL_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;     // position[31:0], time_ms[63:32], motor_speed[87:64]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // stalled[0], checked[1], measured_speed[33:2], zero
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Mirror of the block: register file and stored sample.
  cfg_t        regs_model = '{RST_SPEED_THR, RST_DEV_FRAC, RST_SCALE, RST_MAX_GAP, RST_MIN_POS};
  logic [31:0] last_pos = '0;
  logic [31:0] last_stamp = '0;

  logic [87:0] sample_queue[$];
  result_t     expected_words[$];
  result_t     due;

  longint      gen_pos = 0;
  logic [31:0] gen_stamp = '0;
  int          queued_count = 0;
  int          words_in = 0;
  int          words_out = 0;
  int          errors = 0;
  int          send_idle = 0;
  int          sink_idle = 0;
  int          hold_left = 0;
  int          stuck_cycles = 0;
  bit          calm = 1'b0;

  motor_stall_detector DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #10 clk = ~clk;

  // Works out the result of one accepted sample and updates the stored sample.
  task automatic track_sample(input logic [87:0] word);
    logic signed [31:0] pos;
    logic [31:0]        now;
    logic [31:0]        gap;
    logic [31:0]        speed;
    logic [23:0]        motor;
    logic [63:0]        mag;
    logic [63:0]        quo;
    logic [63:0]        scaled;
    logic [63:0]        upper;
    logic [63:0]        lower;
    longint             diff;
    result_t            res;
    pos = word[31:0];
    now = word[63:32];
    motor = word[87:64];
    gap = now - last_stamp;
    res = '0;
    res.checked = (gap != 0) && (gap < {16'd0, regs_model.max_gap_ms}) &&
                  (pos > $signed(regs_model.min_position));
    if (res.checked) begin
      diff = longint'(pos) - longint'($signed(last_pos));
      mag = (diff < 0) ? 64'(-diff) : 64'(diff);
      quo = (mag * 64'(MS_PER_S)) / {32'd0, gap};
      speed = (quo > 64'hFFFF_FFFF) ? '1 : quo[31:0];
      res.measured_speed = speed;
      if (speed > {8'd0, regs_model.speed_threshold} && motor > regs_model.speed_threshold) begin
        scaled = ({40'd0, motor} * {40'd0, regs_model.speed_scale} + 64'd32768) >> 16;
        upper = ({32'd0, speed} * (64'd65536 + {48'd0, regs_model.deviation_fraction})
                 + 64'd32768) >> 16;
        lower = ({32'd0, speed} * (64'd65536 - {48'd0, regs_model.deviation_fraction})
                 + 64'd32768) >> 16;
        res.stalled = (scaled > upper) || (scaled < lower);
      end
    end
    // A stall keeps the old sample as the reference for the next one.
    if (!res.stalled) begin
      last_pos = pos;
      last_stamp = now;
    end
    expected_words.push_back(res);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_SPEED_THR: regs_model.speed_threshold = value[23:0];
      REG_DEV_FRAC:  regs_model.deviation_fraction = value[15:0];
      REG_SCALE:     regs_model.speed_scale = value[23:0];
      REG_MAX_GAP:   regs_model.max_gap_ms = value[15:0];
      REG_MIN_POS:   regs_model.min_position = value;
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [31:0] thr, input logic [31:0] dev,
                         input logic [31:0] scale, input logic [31:0] gap,
                         input logic [31:0] min_pos);
    apb_write(REG_SPEED_THR, thr);
    apb_write(REG_DEV_FRAC, dev);
    apb_write(REG_SCALE, scale);
    apb_write(REG_MAX_GAP, gap);
    apb_write(REG_MIN_POS, min_pos);
  endtask

  task automatic add_sample(input logic [31:0] pos, input logic [31:0] stamp,
                            input logic [23:0] motor);
    gen_pos = longint'($signed(pos));
    gen_stamp = stamp;
    sample_queue.push_back({motor, stamp, pos});
    queued_count++;
  endtask

  // Mostly plausible motion whose commanded speed roughly matches the encoder,
  // mixed with mismatches, zero gaps, overlong gaps and raw noise.
  task automatic queue_random(input int count);
    longint      p;
    longint      d;
    longint      lo;
    logic [31:0] gap;
    logic [31:0] stamp;
    logic [63:0] spd;
    logic [63:0] m;
    int          mg;
    for (int i = 0; i < count; i++) begin
      mg = regs_model.max_gap_ms;
      if ($urandom_range(0, 99) < 78) begin
        if (mg <= 1) gap = 1;
        else if ($urandom_range(0, 3) == 0) gap = $urandom_range(1, mg - 1);
        else gap = $urandom_range(1, (mg - 1 < 50) ? mg - 1 : 50);
        d = longint'($urandom_range(0, 1 << $urandom_range(0, 20)));
        if ($urandom_range(0, 15) == 0) d = longint'($urandom);
        if ($urandom_range(0, 1) == 1) d = -d;
        p = gen_pos + d;
        lo = longint'($signed(regs_model.min_position)) + 1;
        if (p < lo) p = lo;
        if (p > POS_MAX) p = POS_MAX;
        stamp = gen_stamp + gap;
        d = p - gen_pos;
        if (d < 0) d = -d;
        spd = 64'(d) * 64'(MS_PER_S) / {32'd0, gap};
        if (spd > 64'hFFFF_FFFF) spd = 64'hFFFF_FFFF;
        if (regs_model.speed_scale == 0) m = 64'($urandom);
        else m = (spd * 64'd65536 + 64'(regs_model.speed_scale / 2)) / 64'(regs_model.speed_scale);
        case ($urandom_range(0, 7))
          0, 1: m = m * $urandom_range(0, 300) / 100;
          2, 3: m = m + $urandom_range(0, 4) - 2;
          4: m = 64'($urandom);
          default: ;
        endcase
        if (m > 64'hFF_FFFF) m = ($urandom_range(0, 1) == 1) ? 64'hFF_FFFF : (m & 64'hFF_FFFF);
      end else begin
        case ($urandom_range(0, 2))
          0: stamp = $urandom;
          1: stamp = gen_stamp;
          default: stamp = gen_stamp + mg + $urandom_range(0, 1000);
        endcase
        p = longint'($signed($urandom));
        m = 64'($urandom);
      end
      add_sample(p[31:0], stamp, m[23:0]);
    end
  endtask

  // Waits until every queued word has gone in and every result has come out,
  // then lets the block settle before the registers change.
  task automatic drain_and_settle();
    while (words_in != queued_count || expected_words.size() != 0) @(negedge clk);
    repeat (60) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      send_idle = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        track_sample(in_tdata);
        words_in++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_idle > 0) begin
          send_idle--;
          in_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          send_idle = $urandom_range(1, 8) - 1;
          in_tvalid <= 1'b0;
        end else if (sample_queue.size() > 0) begin
          in_tdata <= sample_queue.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_idle = 0;
      hold_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        words_out++;
        if (expected_words.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word %h", out_tdata);
        end else begin
          due = expected_words.pop_front();
          if (out_tdata[0] !== due.stalled || out_tdata[1] !== due.checked ||
              out_tdata[33:2] !== due.measured_speed) begin
            errors++;
            if (errors <= 10)
              $display("word %0d: expected stalled=%0b checked=%0b speed=%0d, got %0b %0b %0d",
                       words_out, due.stalled, due.checked, due.measured_speed,
                       out_tdata[0], out_tdata[1], out_tdata[33:2]);
          end
        end
        // Long back-pressure so the block fills and stops taking input.
        if (words_out == 40 || words_out == 700) hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (sink_idle > 0) begin
        sink_idle--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        sink_idle = $urandom_range(1, 8) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: no stall, stall, unchecked position, zero and long gaps,
    // saturated speed, timestamp wrap, motor speed at the threshold.
    add_sample(32'd0, 32'd0, 24'd0);
    add_sample(32'd1000, 32'd10, 24'd100000);
    add_sample(32'd2000, 32'd20, 24'd300000);
    add_sample(32'd1500, 32'd30, 24'd25000);
    add_sample(-32'sd5, 32'd35, 24'd0);
    add_sample(32'd100, 32'd200, 24'd0);
    add_sample(32'h7FFF_FFFF, 32'd201, 24'hFF_FFFF);
    add_sample(32'd200, 32'hFFFF_FFF0, 24'd7);
    add_sample(32'd300, 32'd5, 24'd4761);
    add_sample(32'd400, 32'd6, 24'd0);
    add_sample(32'd5000, 32'd6, 24'd1);
    drain_and_settle();

    // Exact match required, widest gap window, lowest minimum position.
    // The deviation value carries high bits that the register drops.
    set_all(32'd0, 32'hABCD_0000, 32'd65536, 32'd65535, 32'h8000_0000);
    add_sample(32'h8000_0000, 32'h8000_0000, 24'd0);
    add_sample(32'h7FFF_FFFF, 32'h8000_0001, 24'hFF_FFFF);
    add_sample(32'h8000_0001, 32'h8000_0003, 24'd333);
    add_sample(32'h7FFF_FFFF, 32'h8000_03EB, 24'hFF_FFFF);
    add_sample(32'h8000_0002, 32'h8001_0001, 24'd9);
    add_sample(32'd0, 32'h8002_0000, 24'd5);
    add_sample(32'd1000, 32'h8002_0001, 24'd1000000);
    add_sample(32'd2000, 32'h8002_0002, 24'd1000001);
    queue_random(100);
    drain_and_settle();

    set_all(32'hA500_03E8, 32'd13107, 32'd65536, 32'd100, 32'h8000_0000);
    queue_random(190);
    drain_and_settle();

    set_all(32'hFF_FFFF, 32'hFFFF, 32'hFF_FFFF, 32'hFFFF, 32'd0);
    queue_random(150);
    drain_and_settle();

    // Nothing can be checked here.
    set_all(32'd0, 32'd0, 32'd0, 32'd1, 32'h7FFF_FFFF);
    queue_random(80);
    drain_and_settle();

    set_all($urandom_range(0, 5000), $urandom, $urandom_range(16384, 262144),
            $urandom_range(2, 2000), -$urandom_range(0, 1000000));
    apb_write(REG_UNUSED, $urandom);
    queue_random(190);
    drain_and_settle();

    set_all($urandom_range(0, 5000) | 32'h5A00_0000, $urandom,
            $urandom_range(16384, 262144) | 32'hC300_0000,
            $urandom_range(2, 2000) | 32'h0042_0000, -$urandom_range(0, 1000000));
    queue_random(190);
    drain_and_settle();

    calm = 1'b1;
    set_all(32'd50, 32'd6554, 32'd131072, 32'd500, -32'sd1000);
    queue_random(190);

    while (words_in != queued_count || expected_words.size() != 0) @(negedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ----- motor_stall_detector.f -----
hdl/msd_pkg.sv
hdl/msd_ctrl.sv
hdl/msd_dp.sv
hdl/motor_stall_detector.sv
sim/motor_stall_detector_tb.sv
